@@ src/token_bucket_packet_shaper_defines.svh @@
// assertion macros for the token bucket shaper
`ifndef TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define TBPS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define TBPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TBPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tbps_pkg.sv @@
// shared types, codes and defaults of the token bucket shaper
package tbps_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam logic [15:0] DEPTH_AT_RESET = 16'd10;

	// event kinds
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_PACKET = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_TOKEN_KEPT    = 3'd0;
	localparam logic [2:0] STAT_TOKEN_DROPPED = 3'd1;
	localparam logic [2:0] STAT_PKT_QUEUED    = 3'd2;
	localparam logic [2:0] STAT_PKT_TOO_BIG   = 3'd3;
	localparam logic [2:0] STAT_QUEUE_FULL    = 3'd4;

	// one queued packet
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] need;
	} entry_t;

endpackage

@@ src/tbps_queue_mem.sv @@
// packet queue storage: one write port, one registered read port
module tbps_queue_mem #(
	parameter int DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [PTR_W-1:0]     wr_addr,
	input  tbps_pkg::entry_t     wr_data,
	input  logic [PTR_W-1:0]     rd_addr,
	output tbps_pkg::entry_t     rd_data
);

	tbps_pkg::entry_t mem [DEPTH];
	tbps_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/tbps_core.sv @@
// event sequencer: bucket arithmetic, queue pointers and result register
`include "token_bucket_packet_shaper_defines.svh"

module tbps_core #(
	parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          bucket_depth,
	// event channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [15:0]          need,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [31:0]          packet_number,
	output logic                 released,
	output logic [31:0]          released_id,
	output logic [15:0]          released_need,
	output logic [15:0]          tokens_now,
	output logic [6:0]           queue_count,
	// queue memory
	output logic                 mem_wr_en,
	output logic [PTR_W-1:0]     mem_wr_addr,
	output tbps_pkg::entry_t     mem_wr_data,
	output logic [PTR_W-1:0]     mem_rd_addr,
	input  tbps_pkg::entry_t     mem_rd_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic               state_q;
	logic               cmd_q;
	logic [15:0]        need_q;
	logic [15:0]        token_q;
	logic [31:0]        seq_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [31:0]        pnum_q;
	logic               rel_q;
	logic [31:0]        rel_id_q;
	logic [15:0]        rel_need_q;
	logic [15:0]        tokens_q;
	logic [6:0]         qcount_q;

	logic               go;
	logic               is_tick;
	logic [16:0]        tok_inc;
	logic               tick_drop;
	logic [31:0]        seq_next;
	logic               too_big;
	logic               full;
	logic               queued;
	logic               check;
	logic [15:0]        tok_mid;
	logic [CNT_W-1:0]   count_mid;
	tbps_pkg::entry_t   head_entry;
	logic               rel;
	logic [15:0]        tok_final;
	logic [CNT_W-1:0]   count_final;
	logic [2:0]         status_d;
	logic [CNT_W+6:0]   count_ext;

	// result register must be free before the event commits
	assign go       = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	assign is_tick   = (cmd_q == tbps_pkg::CMD_TICK);
	assign tok_inc   = {1'b0, token_q} + 17'd1;
	assign tick_drop = tok_inc > {1'b0, bucket_depth};
	assign seq_next  = seq_q + 32'd1;
	assign too_big   = need_q > bucket_depth;
	assign full      = count_q >= CNT_FULL;
	assign queued    = !is_tick && !too_big && !full;
	assign check     = is_tick ? !tick_drop : queued;
	assign tok_mid   = (is_tick && !tick_drop) ? tok_inc[15:0] : token_q;
	assign count_mid = count_q + CNT_W'(queued);

	// empty queue: the head is the packet arriving right now
	always_comb begin
		if (count_q == '0) begin
			head_entry.id   = seq_next;
			head_entry.need = need_q;
		end else begin
			head_entry = mem_rd_data;
		end
	end

	assign rel         = check && (count_mid != '0) && (tok_mid >= head_entry.need);
	assign tok_final   = rel ? (tok_mid - head_entry.need) : tok_mid;
	assign count_final = count_mid - CNT_W'(rel);
	assign count_ext   = {7'd0, count_final};

	always_comb begin
		if (is_tick) begin
			status_d = tick_drop ? tbps_pkg::STAT_TOKEN_DROPPED : tbps_pkg::STAT_TOKEN_KEPT;
		end else if (too_big) begin
			status_d = tbps_pkg::STAT_PKT_TOO_BIG;
		end else if (full) begin
			status_d = tbps_pkg::STAT_QUEUE_FULL;
		end else begin
			status_d = tbps_pkg::STAT_PKT_QUEUED;
		end
	end

	assign mem_wr_en        = go && queued;
	assign mem_wr_addr      = tail_q;
	assign mem_wr_data.id   = seq_next;
	assign mem_wr_data.need = need_q;
	assign mem_rd_addr      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			token_q     <= '0;
			seq_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (go) begin
				token_q <= tok_final;
				count_q <= count_final;
				if (!is_tick) begin
					seq_q <= seq_next;
				end
				if (queued) begin
					tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				end
				if (rel) begin
					head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			need_q <= need;
		end
		if (go) begin
			status_q   <= status_d;
			pnum_q     <= is_tick ? 32'd0 : seq_next;
			rel_q      <= rel;
			rel_id_q   <= rel ? head_entry.id : 32'd0;
			rel_need_q <= rel ? head_entry.need : 16'd0;
			tokens_q   <= tok_final;
			qcount_q   <= count_ext[6:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign packet_number = pnum_q;
	assign released      = rel_q;
	assign released_id   = rel_id_q;
	assign released_need = rel_need_q;
	assign tokens_now    = tokens_q;
	assign queue_count   = qcount_q;

	`TBPS_ASSERT(a_count_bound, count_q <= CNT_FULL, "queue count above depth")
	`TBPS_ASSERT_IMP(a_empty_ptrs, count_q == '0, head_q == tail_q, "empty queue with split pointers")
	`TBPS_ASSERT_IMP(a_no_write_full, mem_wr_en, count_q < CNT_FULL, "write into a full queue")
	`TBPS_ASSERT_NXT(a_commit_result, go, out_valid_q && (state_q == ST_IDLE), "commit lost its result")

endmodule

@@ src/token_bucket_packet_shaper.sv @@
// token bucket shaper top level: config register, sequencer and packet queue
//
// usage
// - event channel (in_valid/in_ready): one word per event, cmd selects a token
//   tick or a packet arrival, need gives the packet's token cost
// - result channel (out_valid/out_ready): exactly one word per event, in order,
//   with status, sequence number, released packet, bucket level and queue level
// - config channel (cfg_valid/cfg_ready): writes bucket_depth, always ready;
//   write it only while no event is in flight
// - a result becomes valid when its event commits: the queue head read
//   starts at the accepting edge, and the commit edge updates the bucket and
//   pointers and loads the result register
// - the queue memory's head read is registered, so a new event is accepted only
//   after the previous one commits; in_ready is high whenever no event is in flight
// - a new event is accepted while the previous result still waits; if the
//   receiver stalls, that event holds before commit until the result register
//   frees, and the head is re-read every cycle meanwhile
// - reset clears bucket, sequence counter, pointers and count and sets
//   bucket_depth to 10; queue memory contents are not cleared
module token_bucket_packet_shaper #(
	parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] bucket_depth,
	// events in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] need,
	// results out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] packet_number,
	output logic        released,
	output logic [31:0] released_id,
	output logic [15:0] released_need,
	output logic [15:0] tokens_now,
	output logic [6:0]  queue_count
);

	// bucket depth register, live value used by every event
	logic [15:0] depth_q;

	// queue memory hookup
	logic              mem_wr_en;
	logic [PTR_W-1:0]  mem_wr_addr;
	tbps_pkg::entry_t  mem_wr_data;
	logic [PTR_W-1:0]  mem_rd_addr;
	tbps_pkg::entry_t  mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= tbps_pkg::DEPTH_AT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			depth_q <= bucket_depth;
		end
	end

	// per-event sequencing and bucket math
	tbps_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.bucket_depth  (depth_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.need          (need),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.packet_number (packet_number),
		.released      (released),
		.released_id   (released_id),
		.released_need (released_need),
		.tokens_now    (tokens_now),
		.queue_count   (queue_count),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data)
	);

	// packet ids and needs, addressed by the ring pointers
	tbps_queue_mem #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule
